FILE: hdl/swhf_pkg.sv
// ----------------------------------------------------------------------------
// swhf_pkg
// Shared types and constants for the sliding window handle FIFO.
// ----------------------------------------------------------------------------
package swhf_pkg;

    // Default window storage depth
    localparam int DEPTH_DEFAULT = 16;

    // Field widths
    localparam int HANDLE_W = 32;
    localparam int LIMIT_W  = 5;
    localparam int COUNT_W  = 5;

    // window_limit after reset
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 5'd16;

    // Operation codes
    typedef enum logic [1:0] {
        FUNC_INSERT = 2'd0,
        FUNC_UPDATE = 2'd1,
        FUNC_DELETE = 2'd2,
        FUNC_CLEAR  = 2'd3
    } func_t;

    // Result kinds
    localparam logic KIND_EVICT = 1'b0;
    localparam logic KIND_DONE  = 1'b1;

    // One result item
    typedef struct packed {
        logic                kind;
        logic [HANDLE_W-1:0] evicted_handle;
        logic [COUNT_W-1:0]  match_count;
        logic [COUNT_W-1:0]  occupancy;
        logic                last;
    } result_t;

endpackage

FILE: hdl/swhf_ram.sv
// ----------------------------------------------------------------------------
// swhf_ram
// Window entry storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module swhf_ram #(
    parameter int DEPTH = swhf_pkg::DEPTH_DEFAULT
) (
    input  logic                       clk,
    input  logic                       we,
    input  logic [$clog2(DEPTH)-1:0]   waddr,
    input  logic [31:0]                wdata,
    input  logic                       re,
    input  logic [$clog2(DEPTH)-1:0]   raddr,
    output logic [31:0]                rdata
);
    logic [31:0] mem [DEPTH];
    logic [31:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read port, data holds until the next read
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: hdl/swhf_out_reg.sv
// ----------------------------------------------------------------------------
// swhf_out_reg
// Result output register: holds one result item until the sink takes it.
// ----------------------------------------------------------------------------
module swhf_out_reg (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  swhf_pkg::result_t result,
    output logic              free,
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [47:0]       m_axis_tdata,
    output logic [0:0]        m_axis_tuser,
    output logic              m_axis_tlast
);
    import swhf_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t data_reg;

    // Register can take a new item when empty or being drained
    assign free = !valid_reg || m_axis_tready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= result;
        end
    end

    assign m_axis_tvalid = valid_reg;
    assign m_axis_tdata  = {6'd0, data_reg.occupancy, data_reg.match_count,
                            data_reg.evicted_handle};
    assign m_axis_tuser  = data_reg.kind;
    assign m_axis_tlast  = data_reg.last;

endmodule

FILE: hdl/sliding_window_handle_fifo.sv
// ----------------------------------------------------------------------------
// sliding_window_handle_fifo
// Ordered window of 32-bit handles kept as a circular buffer in one RAM.
// ----------------------------------------------------------------------------
//  Channel  | Direction | Payload
//  s_axis   | in        | tuser: func; tdata: handle, new_handle
//  m_axis   | out       | tuser: kind; tdata: evicted_handle, match_count,
//           |           | occupancy; tlast: last
//  cfg      | in        | cfg_wdata: window_limit, written when cfg_we
//
//  Insert: evicts the front handle (RAM read of the front) while full, then appends.
//  Update and delete: one RAM read per stored entry.
//  Clear: empties the window.
//  Reset empties the window at once; RAM contents are not cleared.
//  A result held in the output register while the sink is not ready stalls
//  the sequencer when it has the next result to load.
// ----------------------------------------------------------------------------
module sliding_window_handle_fifo #(
    parameter int WINDOW_DEPTH = swhf_pkg::DEPTH_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    // Input items
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // handle[31:0], new_handle[63:32]
    input  logic [1:0]  s_axis_tuser,   // func[1:0]
    // Result items
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // evicted_handle[31:0],
                                        // match_count[36:32], occupancy[41:37]
    output logic [0:0]  m_axis_tuser,   // kind[0]
    output logic        m_axis_tlast,
    // Configuration
    input  logic        cfg_we,
    input  logic [4:0]  cfg_wdata       // window_limit
);
    import swhf_pkg::*;

    localparam int AW = $clog2(WINDOW_DEPTH);
    localparam int CW = $clog2(WINDOW_DEPTH + 1);

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_EV_RD  = 5'b00010,
        ST_EV_OUT = 5'b00100,
        ST_WALK   = 5'b01000,
        ST_FIN    = 5'b10000
    } state_t;

    state_t               state_reg, state_next;
    logic [LIMIT_W-1:0]   limit_reg;
    logic [AW-1:0]        head_reg, head_next;
    logic [CW-1:0]        count_reg, count_next;
    logic [CW-1:0]        rd_idx_reg, rd_idx_next;
    logic [CW-1:0]        proc_idx_reg, proc_idx_next;
    logic                 proc_valid_reg, proc_valid_next;
    logic [CW-1:0]        kept_reg, kept_next;
    logic [CW-1:0]        match_reg, match_next;
    func_t                func_reg;
    logic [HANDLE_W-1:0]  key_reg;
    logic [HANDLE_W-1:0]  repl_reg;

    logic                 ram_we;
    logic [AW-1:0]        ram_waddr;
    logic [31:0]          ram_wdata;
    logic                 ram_re;
    logic [AW-1:0]        ram_raddr;
    logic [31:0]          ram_rdata;

    logic                 out_load;
    logic                 out_free;
    result_t              out_result;
    logic [CW-1:0]        lim_eff;
    logic                 in_fire;
    logic [31:0]          count_dec32;
    logic [31:0]          count32;
    logic [31:0]          match32;

    // Circular address of offset off from base
    function automatic logic [AW-1:0] wrap_addr(input logic [AW-1:0] base,
                                                input logic [CW-1:0] off);
        logic [CW:0] s;
        s = (CW+1)'(base) + (CW+1)'(off);
        if (s >= (CW+1)'(WINDOW_DEPTH))
        begin
            s = s - (CW+1)'(WINDOW_DEPTH);
        end
        return s[AW-1:0];
    endfunction

    // Effective window limit, clamped to 1..depth
    always_comb
    begin
        if (limit_reg == '0)
        begin
            lim_eff = CW'(1);
        end
        else if (int'(limit_reg) > WINDOW_DEPTH)
        begin
            lim_eff = CW'(WINDOW_DEPTH);
        end
        else
        begin
            lim_eff = CW'(limit_reg);
        end
    end

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign count_dec32   = 32'(count_reg) - 32'd1;
    assign count32       = 32'(count_reg);
    assign match32       = 32'(match_reg);

    // Sequencer
    always_comb
    begin
        state_next      = state_reg;
        head_next       = head_reg;
        count_next      = count_reg;
        rd_idx_next     = rd_idx_reg;
        proc_idx_next   = proc_idx_reg;
        proc_valid_next = 1'b0;
        kept_next       = kept_reg;
        match_next      = match_reg;
        ram_we          = 1'b0;
        ram_waddr       = '0;
        ram_wdata       = '0;
        ram_re          = 1'b0;
        ram_raddr       = '0;
        out_load        = 1'b0;
        out_result      = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    match_next  = '0;
                    rd_idx_next = '0;
                    kept_next   = '0;
                    case (func_t'(s_axis_tuser))
                        FUNC_INSERT: state_next = ST_EV_RD;
                        FUNC_UPDATE: state_next = ST_WALK;
                        FUNC_DELETE: state_next = ST_WALK;
                        default:
                        begin
                            count_next = '0;
                            state_next = ST_FIN;
                        end
                    endcase
                end
            end

            // Evict the front while full, otherwise append at the back
            ST_EV_RD:
            begin
                if (count_reg >= lim_eff)
                begin
                    ram_re     = 1'b1;
                    ram_raddr  = head_reg;
                    state_next = ST_EV_OUT;
                end
                else
                begin
                    ram_we     = 1'b1;
                    ram_waddr  = wrap_addr(head_reg, count_reg);
                    ram_wdata  = key_reg;
                    count_next = count_reg + CW'(1);
                    state_next = ST_FIN;
                end
            end

            ST_EV_OUT:
            begin
                if (out_free)
                begin
                    out_load                  = 1'b1;
                    out_result.kind           = KIND_EVICT;
                    out_result.evicted_handle = ram_rdata;
                    out_result.occupancy      = count_dec32[COUNT_W-1:0];
                    out_result.last           = 1'b0;
                    head_next                 = wrap_addr(head_reg, CW'(1));
                    count_next                = count_reg - CW'(1);
                    state_next                = ST_EV_RD;
                end
            end

            // Read one entry per cycle, process it the cycle after
            ST_WALK:
            begin
                if (rd_idx_reg < count_reg)
                begin
                    ram_re          = 1'b1;
                    ram_raddr       = wrap_addr(head_reg, rd_idx_reg);
                    rd_idx_next     = rd_idx_reg + CW'(1);
                    proc_idx_next   = rd_idx_reg;
                    proc_valid_next = 1'b1;
                end
                if (proc_valid_reg)
                begin
                    if (ram_rdata == key_reg)
                    begin
                        match_next = match_reg + CW'(1);
                        if (func_reg == FUNC_UPDATE)
                        begin
                            ram_we    = 1'b1;
                            ram_waddr = wrap_addr(head_reg, proc_idx_reg);
                            ram_wdata = repl_reg;
                        end
                    end
                    else if (func_reg == FUNC_DELETE)
                    begin
                        ram_we    = 1'b1;
                        ram_waddr = wrap_addr(head_reg, kept_reg);
                        ram_wdata = ram_rdata;
                        kept_next = kept_reg + CW'(1);
                    end
                end
                else if (rd_idx_reg == count_reg)
                begin
                    if (func_reg == FUNC_DELETE)
                    begin
                        count_next = kept_reg;
                    end
                    state_next = ST_FIN;
                end
            end

            ST_FIN:
            begin
                if (out_free)
                begin
                    out_load               = 1'b1;
                    out_result.kind        = KIND_DONE;
                    out_result.match_count = match32[COUNT_W-1:0];
                    out_result.occupancy   = count32[COUNT_W-1:0];
                    out_result.last        = 1'b1;
                    state_next             = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            limit_reg      <= LIMIT_RESET;
            head_reg       <= '0;
            count_reg      <= '0;
            rd_idx_reg     <= '0;
            proc_idx_reg   <= '0;
            proc_valid_reg <= 1'b0;
            kept_reg       <= '0;
            match_reg      <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            head_reg       <= head_next;
            count_reg      <= count_next;
            rd_idx_reg     <= rd_idx_next;
            proc_idx_reg   <= proc_idx_next;
            proc_valid_reg <= proc_valid_next;
            kept_reg       <= kept_next;
            match_reg      <= match_next;
            if (cfg_we)
            begin
                limit_reg <= cfg_wdata;
            end
        end
    end

    // Captured item
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            func_reg <= func_t'(s_axis_tuser);
            key_reg  <= s_axis_tdata[31:0];
            repl_reg <= s_axis_tdata[63:32];
        end
    end

    swhf_ram #(
        .DEPTH (WINDOW_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    swhf_out_reg u_out (
        .clk           (clk),
        .rst_n         (rst_n),
        .load          (out_load),
        .result        (out_result),
        .free          (out_free),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

FILE: hdl/swhf_checker.sv
// ----------------------------------------------------------------------------
// swhf_checker
// Port-level checks on the result stream of the sliding window FIFO.
// ----------------------------------------------------------------------------
module swhf_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [47:0] m_axis_tdata,
    input logic [0:0]  m_axis_tuser,
    input logic        m_axis_tlast
);
    // Stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tuser) && $stable(m_axis_tlast))
        else $error("result changed while stalled");

    // Only the done result closes an operation
    a_last_done: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tlast == m_axis_tuser[0])
        else $error("tlast does not match done kind");

    // Eviction reports carry no match count
    a_evict_nomatch: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata[36:32] == 5'd0)
        else $error("eviction report with nonzero match count");

    // Done results carry no evicted handle
    a_done_nohandle: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata[31:0] == 32'd0)
        else $error("done result with nonzero handle");

endmodule

bind sliding_window_handle_fifo swhf_checker u_swhf_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);
